>>> src/ccr_pkg.sv
`default_nettype none

package ccr_pkg;

  localparam int MAX_POINTS = 64;
  localparam int MIN_POINTS = 4;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int IDX_W      = 6;
  localparam int CNT_W      = 7;
  localparam int COORD_W    = 32;
  localparam int FRAC_W     = 16;
  localparam int NUM_LANES  = 3;
  localparam int PT_W       = NUM_LANES * COORD_W;
  // Horner accumulators stay below 50 * 2^31 in magnitude.
  localparam int ACC_W      = 38;
  localparam int PROD_W     = ACC_W + FRAC_W + 1;

  localparam logic [CNT_W-1:0] RESET_COUNT = CNT_W'(MIN_POINTS);

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_EVAL  = 1'b1
  } op_e;

  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [COORD_W-1:0] coord_t;

  localparam acc_t  ACC_ONE    = ACC_W'(1);
  localparam acc_t  COORD_MAX  = (ACC_W'(1) <<< (COORD_W - 1)) - ACC_W'(1);
  localparam acc_t  COORD_MIN  = -(ACC_W'(1) <<< (COORD_W - 1));
  localparam prod_t ROUND_HALF = PROD_W'(1) <<< (FRAC_W - 1);

  typedef struct packed {
    acc_t h;
    acc_t g;
    acc_t b2;
    acc_t b1;
    acc_t p1x2;
  } horner_t;

  typedef struct packed {
    prod_t hp;
    prod_t gp;
    acc_t  b2;
    acc_t  b1;
    acc_t  p1x2;
  } product_t;

  typedef struct packed {
    logic [FRAC_W-1:0]              frac;
    horner_t [NUM_LANES-1:0]        lane;
  } hstage_t;

  typedef struct packed {
    logic [FRAC_W-1:0]              frac;
    product_t [NUM_LANES-1:0]       lane;
  } pstage_t;

  typedef struct packed {
    coord_t value;
    logic   sat;
  } clip_t;

  // Doubled Catmull-Rom coefficients; h starts at b3, g at 3*b3.
  function automatic horner_t init_lane(coord_t p0, coord_t p1, coord_t p2, coord_t p3);
    acc_t    e0, e1, e2, e3;
    horner_t r;
    e0 = ACC_W'(p0);
    e1 = ACC_W'(p1);
    e2 = ACC_W'(p2);
    e3 = ACC_W'(p3);
    r.h    = e3 - e0 + 3 * (e1 - e2);
    r.g    = 3 * (e3 - e0) + 9 * (e1 - e2);
    r.b2   = 2 * e0 - 5 * e1 + 4 * e2 - e3;
    r.b1   = e2 - e0;
    r.p1x2 = 2 * e1;
    return r;
  endfunction

  function automatic prod_t mul_frac(acc_t a, logic [FRAC_W-1:0] frac);
    logic signed [FRAC_W:0] fs;
    fs = $signed({1'b0, frac});
    return PROD_W'(a) * PROD_W'(fs);
  endfunction

  // Round to nearest (ties up) back to the accumulator scale, then add.
  function automatic acc_t round_add(prod_t p, acc_t c);
    prod_t t;
    t = p + ROUND_HALF;
    return $signed(t[FRAC_W +: ACC_W]) + c;
  endfunction

  function automatic clip_t halve_clip(acc_t h);
    acc_t  q;
    clip_t r;
    q = (h + ACC_ONE) >>> 1;
    if (q > COORD_MAX) begin
      r.value = COORD_MAX[COORD_W-1:0];
      r.sat   = 1'b1;
    end else if (q < COORD_MIN) begin
      r.value = COORD_MIN[COORD_W-1:0];
      r.sat   = 1'b1;
    end else begin
      r.value = q[COORD_W-1:0];
      r.sat   = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/closed_catmull_rom_evaluator_top.sv
// Throughput: one word per cycle while the output is not stalled, writes and evaluations alike, in any mix.
// Path: an evaluate word passes ten stages (index split, table read, coefficients,
// six Horner steps, saturation) before its result shows; an output stall holds it in place.
// A write word lands in the point table at its acceptance edge and gives no result.
// Reset clears the pipeline valids and sets the point count to 4; the table
// itself is not cleared and must be written before it is read.
`default_nettype none

module closed_catmull_rom_evaluator_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic        [ccr_pkg::CNT_W-1:0]    cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                operation_i,
  input  logic        [ccr_pkg::IDX_W-1:0]    point_index_i,
  input  logic signed [ccr_pkg::COORD_W-1:0]  coord_x_i,
  input  logic signed [ccr_pkg::COORD_W-1:0]  coord_y_i,
  input  logic signed [ccr_pkg::COORD_W-1:0]  coord_z_i,
  input  logic        [ccr_pkg::FRAC_W-1:0]   global_t_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [ccr_pkg::COORD_W-1:0]  pos_x_o,
  output logic signed [ccr_pkg::COORD_W-1:0]  pos_y_o,
  output logic signed [ccr_pkg::COORD_W-1:0]  pos_z_o,
  output logic signed [ccr_pkg::COORD_W-1:0]  tangent_x_o,
  output logic signed [ccr_pkg::COORD_W-1:0]  tangent_y_o,
  output logic signed [ccr_pkg::COORD_W-1:0]  tangent_z_o,
  output logic                                saturated_o
);

  import ccr_pkg::*;

  // Stage map: 0 index split, 1 table read data, 2 coefficients,
  // 3/5/7 multiply by the fraction, 4/6/8 round and add, 9 output register.
  localparam int NUM_STG = 10;
  localparam int LAST    = NUM_STG - 1;

  logic [CNT_W-1:0]   point_count_q;
  logic [CNT_W-1:0]   n_eff;

  logic [NUM_STG-1:0] vld_q, vld_d;
  logic [NUM_STG-1:0] move;
  logic [NUM_STG-1:0] free;

  logic               in_acc, eval_acc, wr_en;
  logic [ADDR_W-1:0]  waddr;
  logic [PT_W-1:0]    wdata;

  logic [FRAC_W+CNT_W-1:0] scaled;
  logic [ADDR_W-1:0]  seg0_q;
  logic [FRAC_W-1:0]  frac0_q, frac1_q;

  logic [CNT_W-1:0]   seg_w, last_idx, nxt1, nxt2, ix0, ix2, ix3;
  logic [ADDR_W-1:0]  raddr [4];

  // Two copies of the table, each read at two addresses per cycle.
  logic [PT_W-1:0]    mem_a_q [MAX_POINTS];
  logic [PT_W-1:0]    mem_b_q [MAX_POINTS];
  logic [PT_W-1:0]    rd_q    [4];

  hstage_t s2_d, s2_q, s4_d, s4_q, s6_d, s6_q, s8_d, s8_q;
  pstage_t s3_d, s3_q, s5_d, s5_q, s7_d, s7_q;

  clip_t                   pos_c [NUM_LANES];
  clip_t                   tan_c [NUM_LANES];
  coord_t [NUM_LANES-1:0]  pos_d, pos_q, tan_d, tan_q;
  logic                    sat_d, sat_q;

  // ---------------------------------------------------------------------------
  // Configuration: clamp the point count into the supported range.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count_q <= RESET_COUNT;
    end else if (cfg_we_i) begin
      point_count_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (point_count_q < CNT_W'(MIN_POINTS)) begin
      n_eff = CNT_W'(MIN_POINTS);
    end else if (point_count_q > CNT_W'(MAX_POINTS)) begin
      n_eff = CNT_W'(MAX_POINTS);
    end else begin
      n_eff = point_count_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control: a stage moves when the next one is empty or moving too.
  // A write word needs stage 0 free as well, so any evaluation ahead of it
  // reads the table at or before the edge the write lands.
  // ---------------------------------------------------------------------------
  always_comb begin
    free[LAST] = !vld_q[LAST] || out_ready_i;
    move[LAST] = vld_q[LAST] && out_ready_i;
    for (int k = LAST - 1; k >= 0; k--) begin
      move[k] = vld_q[k] && free[k+1];
      free[k] = !vld_q[k] || move[k];
    end
    vld_d[0] = eval_acc || (vld_q[0] && !move[0]);
    for (int k = 1; k < NUM_STG; k++) begin
      vld_d[k] = move[k-1] || (vld_q[k] && !move[k]);
    end
  end

  assign in_ready_o = free[0];
  assign in_acc     = in_valid_i && in_ready_o;
  assign eval_acc   = in_acc && (operation_i == OP_EVAL);
  assign wr_en      = in_acc && (operation_i == OP_WRITE)
                      && (int'(point_index_i) < MAX_POINTS);
  assign waddr      = ADDR_W'(point_index_i);
  assign wdata      = {coord_z_i, coord_y_i, coord_x_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: scale t by the count; the integer part is the segment.
  // ---------------------------------------------------------------------------
  assign scaled = global_t_i * n_eff;

  always_ff @(posedge clk_i) begin
    if (eval_acc) begin
      seg0_q  <= scaled[FRAC_W +: ADDR_W];
      frac0_q <= scaled[FRAC_W-1:0];
    end
  end

  // Four neighbors around the segment, wrapping at the count.
  always_comb begin
    seg_w    = CNT_W'(seg0_q);
    last_idx = n_eff - CNT_W'(1);
    ix0      = (seg_w == '0) ? last_idx : seg_w - CNT_W'(1);
    nxt1     = seg_w + CNT_W'(1);
    ix2      = (nxt1 == n_eff) ? '0 : nxt1;
    nxt2     = ix2 + CNT_W'(1);
    ix3      = (nxt2 == n_eff) ? '0 : nxt2;
    raddr[0] = ix0[ADDR_W-1:0];
    raddr[1] = seg0_q;
    raddr[2] = ix2[ADDR_W-1:0];
    raddr[3] = ix3[ADDR_W-1:0];
  end

  // ---------------------------------------------------------------------------
  // Point table: write both copies, read registered when stage 0 advances.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_a_q[waddr] <= wdata;
      mem_b_q[waddr] <= wdata;
    end
    if (move[0]) begin
      rd_q[0] <= mem_a_q[raddr[0]];
      rd_q[1] <= mem_a_q[raddr[1]];
      rd_q[2] <= mem_b_q[raddr[2]];
      rd_q[3] <= mem_b_q[raddr[3]];
      frac1_q <= frac0_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath: coefficients, then Horner for position (three steps) and for
  // the derivative (two steps), alternating multiply and round-add stages.
  // ---------------------------------------------------------------------------
  always_comb begin
    s2_d.frac = frac1_q;
    s3_d.frac = s2_q.frac;
    s4_d.frac = s3_q.frac;
    s5_d.frac = s4_q.frac;
    s6_d.frac = s5_q.frac;
    s7_d.frac = s6_q.frac;
    s8_d.frac = s7_q.frac;
    sat_d     = 1'b0;
    for (int l = 0; l < NUM_LANES; l++) begin
      s2_d.lane[l] = init_lane(rd_q[0][l*COORD_W +: COORD_W], rd_q[1][l*COORD_W +: COORD_W],
                               rd_q[2][l*COORD_W +: COORD_W], rd_q[3][l*COORD_W +: COORD_W]);

      s3_d.lane[l].hp   = mul_frac(s2_q.lane[l].h, s2_q.frac);
      s3_d.lane[l].gp   = mul_frac(s2_q.lane[l].g, s2_q.frac);
      s3_d.lane[l].b2   = s2_q.lane[l].b2;
      s3_d.lane[l].b1   = s2_q.lane[l].b1;
      s3_d.lane[l].p1x2 = s2_q.lane[l].p1x2;

      s4_d.lane[l].h    = round_add(s3_q.lane[l].hp, s3_q.lane[l].b2);
      s4_d.lane[l].g    = round_add(s3_q.lane[l].gp, s3_q.lane[l].b2 <<< 1);
      s4_d.lane[l].b2   = s3_q.lane[l].b2;
      s4_d.lane[l].b1   = s3_q.lane[l].b1;
      s4_d.lane[l].p1x2 = s3_q.lane[l].p1x2;

      s5_d.lane[l].hp   = mul_frac(s4_q.lane[l].h, s4_q.frac);
      s5_d.lane[l].gp   = mul_frac(s4_q.lane[l].g, s4_q.frac);
      s5_d.lane[l].b2   = s4_q.lane[l].b2;
      s5_d.lane[l].b1   = s4_q.lane[l].b1;
      s5_d.lane[l].p1x2 = s4_q.lane[l].p1x2;

      // Derivative is complete here; the position takes one more step.
      s6_d.lane[l].h    = round_add(s5_q.lane[l].hp, s5_q.lane[l].b1);
      s6_d.lane[l].g    = round_add(s5_q.lane[l].gp, s5_q.lane[l].b1);
      s6_d.lane[l].b2   = s5_q.lane[l].b2;
      s6_d.lane[l].b1   = s5_q.lane[l].b1;
      s6_d.lane[l].p1x2 = s5_q.lane[l].p1x2;

      s7_d.lane[l].hp   = mul_frac(s6_q.lane[l].h, s6_q.frac);
      s7_d.lane[l].gp   = PROD_W'(s6_q.lane[l].g);
      s7_d.lane[l].b2   = s6_q.lane[l].b2;
      s7_d.lane[l].b1   = s6_q.lane[l].b1;
      s7_d.lane[l].p1x2 = s6_q.lane[l].p1x2;

      s8_d.lane[l].h    = round_add(s7_q.lane[l].hp, s7_q.lane[l].p1x2);
      s8_d.lane[l].g    = $signed(s7_q.lane[l].gp[ACC_W-1:0]);
      s8_d.lane[l].b2   = s7_q.lane[l].b2;
      s8_d.lane[l].b1   = s7_q.lane[l].b1;
      s8_d.lane[l].p1x2 = s7_q.lane[l].p1x2;

      // Halve back to Q16.16 and saturate.
      pos_c[l] = halve_clip(s8_q.lane[l].h);
      tan_c[l] = halve_clip(s8_q.lane[l].g);
      pos_d[l] = pos_c[l].value;
      tan_d[l] = tan_c[l].value;
      sat_d    = sat_d || pos_c[l].sat || tan_c[l].sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move[1]) s2_q <= s2_d;
    if (move[2]) s3_q <= s3_d;
    if (move[3]) s4_q <= s4_d;
    if (move[4]) s5_q <= s5_d;
    if (move[5]) s6_q <= s6_d;
    if (move[6]) s7_q <= s7_d;
    if (move[7]) s8_q <= s8_d;
    if (move[8]) begin
      pos_q <= pos_d;
      tan_q <= tan_d;
      sat_q <= sat_d;
    end
  end

  // Hold the result word here until the consumer takes it.
  assign out_valid_o = vld_q[LAST];
  assign pos_x_o     = pos_q[0];
  assign pos_y_o     = pos_q[1];
  assign pos_z_o     = pos_q[2];
  assign tangent_x_o = tan_q[0];
  assign tangent_y_o = tan_q[1];
  assign tangent_z_o = tan_q[2];
  assign saturated_o = sat_q;

`ifndef NO_ASSERTIONS
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q == '0) |-> in_ready_o)
    else $error("empty pipeline refuses input");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((&vld_q) && !out_ready_i) |-> !in_ready_o)
    else $error("input taken while every stage is held");

  a_addr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    move[0] |-> ((CNT_W'(raddr[0]) < n_eff) && (CNT_W'(raddr[2]) < n_eff)
                 && (CNT_W'(raddr[3]) < n_eff) && (CNT_W'(raddr[1]) < n_eff)))
    else $error("table read beyond the point count");
`endif

endmodule

`default_nettype wire

>>> tb/closed_catmull_rom_evaluator_top_tb.sv
module closed_catmull_rom_evaluator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ccr_pkg::*;

  // Generous bound on the whole run, in clock cycles.
  localparam int CYCLE_LIMIT = 200000;
  // Cycles to let pass once the last result has come (pipeline depth plus margin).
  localparam int SETTLE_CYCLES = 24;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_WORDS   = 82;

  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][31:0] tan;
    logic             sat;
  } curve_sample_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       cfg_we_i;
  logic [CNT_W-1:0]           cfg_wdata_i;
  logic                       in_valid_i;
  logic                       in_ready_o;
  logic                       operation_i;
  logic [IDX_W-1:0]           point_index_i;
  logic signed [COORD_W-1:0]  coord_x_i;
  logic signed [COORD_W-1:0]  coord_y_i;
  logic signed [COORD_W-1:0]  coord_z_i;
  logic [FRAC_W-1:0]          global_t_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  logic signed [COORD_W-1:0]  pos_x_o;
  logic signed [COORD_W-1:0]  pos_y_o;
  logic signed [COORD_W-1:0]  pos_z_o;
  logic signed [COORD_W-1:0]  tangent_x_o;
  logic signed [COORD_W-1:0]  tangent_y_o;
  logic signed [COORD_W-1:0]  tangent_z_o;
  logic                       saturated_o;

  // Shadow copy of the point table and of the point count register.
  logic signed [31:0] curve_point [MAX_POINTS][3];
  logic [CNT_W-1:0]   ring_size;
  // Curve samples predicted for accepted evaluate words, oldest first.
  curve_sample_t      expected_samples [$];
  curve_sample_t      oldest_sample;

  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned cycle_count;
  int unsigned error_count;

  closed_catmull_rom_evaluator_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .operation_i   (operation_i),
    .point_index_i (point_index_i),
    .coord_x_i     (coord_x_i),
    .coord_y_i     (coord_y_i),
    .coord_z_i     (coord_z_i),
    .global_t_i    (global_t_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pos_x_o       (pos_x_o),
    .pos_y_o       (pos_y_o),
    .pos_z_o       (pos_z_o),
    .tangent_x_o   (tangent_x_o),
    .tangent_y_o   (tangent_y_o),
    .tangent_z_o   (tangent_z_o),
    .saturated_o   (saturated_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Round a value scaled by 2^16 back to nearest, ties upward.
  function automatic longint round_frac(longint x);
    return (x + 64'sd32768) >>> 16;
  endfunction

  // Clip to signed 32 bits; the top bit flags clipping.
  function automatic logic [32:0] clip_word(longint v);
    if (v > 64'sd2147483647) return {1'b1, 32'h7FFF_FFFF};
    if (v < -64'sd2147483648) return {1'b1, 32'h8000_0000};
    return {1'b0, v[31:0]};
  endfunction

  // Position and derivative of the closed curve at global parameter t.
  function automatic curve_sample_t predict_sample(logic [FRAC_W-1:0] t);
    int unsigned   n, scaled, seg, base;
    longint        ff, p0, p1, p2, p3, b3, b2, b1, h, g;
    logic [32:0]   cp, ct;
    curve_sample_t r;
    n = ring_size;
    if (n < MIN_POINTS) n = MIN_POINTS;
    if (n > MAX_POINTS) n = MAX_POINTS;
    scaled = t * n;
    seg    = scaled >> FRAC_W;
    ff     = scaled & 32'hFFFF;
    base   = (seg + n - 1) % n;
    r.sat  = 1'b0;
    for (int c = 0; c < 3; c++) begin
      p0 = curve_point[base][c];
      p1 = curve_point[(base + 1) % n][c];
      p2 = curve_point[(base + 2) % n][c];
      p3 = curve_point[(base + 3) % n][c];
      // Doubled coefficients, evaluated by Horner with rounding per step.
      b3 = -p0 + 3 * p1 - 3 * p2 + p3;
      b2 = 2 * p0 - 5 * p1 + 4 * p2 - p3;
      b1 = p2 - p0;
      h  = round_frac(b3 * ff) + b2;
      h  = round_frac(h * ff) + b1;
      h  = round_frac(h * ff) + 2 * p1;
      g  = round_frac(3 * b3 * ff) + 2 * b2;
      g  = round_frac(g * ff) + b1;
      cp = clip_word((h + 1) >>> 1);
      ct = clip_word((g + 1) >>> 1);
      r.pos[c] = cp[31:0];
      r.tan[c] = ct[31:0];
      r.sat    = r.sat | cp[32] | ct[32];
    end
    return r;
  endfunction

  // Moderate coordinates half the time, with full-range values and rails mixed in.
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3, 4: return $urandom;
      default: return $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
    endcase
  endfunction

  // Send one word, idling at random first; update the shadow state on acceptance.
  task automatic send_word(op_e op, logic [IDX_W-1:0] slot, logic [31:0] x,
                           logic [31:0] y, logic [31:0] z, logic [FRAC_W-1:0] t);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    operation_i   <= op;
    point_index_i <= slot;
    coord_x_i     <= x;
    coord_y_i     <= y;
    coord_z_i     <= z;
    global_t_i    <= t;
    // Hold the word until the block takes it.
    do @(posedge clk_i); while (!in_ready_o);
    if (op == OP_WRITE) begin
      curve_point[slot][0] = x;
      curve_point[slot][1] = y;
      curve_point[slot][2] = z;
    end else begin
      expected_samples.insert(expected_samples.size(), predict_sample(t));
    end
  endtask

  task automatic write_point(logic [IDX_W-1:0] slot, logic [31:0] x, logic [31:0] y,
                             logic [31:0] z);
    // The parameter field is unused on a write: fill it with noise.
    send_word(OP_WRITE, slot, x, y, z, FRAC_W'($urandom));
  endtask

  task automatic eval_at(logic [FRAC_W-1:0] t);
    // Slot and coordinates are unused on an evaluation: fill them with noise.
    send_word(OP_EVAL, IDX_W'($urandom), $urandom, $urandom, $urandom, t);
  endtask

  // Drop valid and wait until every predicted sample came out, then let the pipe empty.
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write the point count register while the block is idle.
  task automatic set_ring_size(logic [CNT_W-1:0] value);
    drain_results();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    ring_size = value;
  endtask

  // Store every slot once so that no evaluation ever reads an unwritten entry.
  task automatic fill_table();
    for (int s = 0; s < MAX_POINTS; s++) begin
      write_point(IDX_W'(s), rand_coord(), rand_coord(), rand_coord());
    end
  endtask

  // Count after reset is four: hit the ends of t and the segment boundaries at 16'h4000 and 16'h8000.
  task automatic test_reset_count();
    eval_at(16'h0000);
    eval_at(16'h0001);
    eval_at(16'h3FFF);
    eval_at(16'h4000);
    eval_at(16'h8000);
    eval_at(16'hFFFF);
  endtask

  // Rail-to-rail neighbors force clipping in the derivative.
  task automatic test_saturation();
    write_point(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    write_point(1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    write_point(2, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    write_point(3, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    eval_at(16'h0000);
    eval_at(16'h2000);
    eval_at(16'h9C40);
  endtask

  // Counts outside [4, MAX_POINTS] clamp; the top count wraps from the last slot to the first.
  task automatic test_count_clamp();
    set_ring_size(7'd0);
    eval_at(16'hFFFF);
    set_ring_size(7'd3);
    eval_at(16'hC000);
    set_ring_size(7'd127);
    eval_at(16'hFFFF);
    eval_at(16'h0000);
    set_ring_size(7'd65);
    eval_at(16'hFC00);
    set_ring_size(7'(MAX_POINTS));
    eval_at(16'hFFFF);
  endtask

  // A write right before an evaluation must be seen by it.
  task automatic test_write_then_eval();
    write_point(63, $urandom, $urandom, $urandom);
    eval_at(16'hFFFF);
    write_point(0, rand_coord(), rand_coord(), rand_coord());
    eval_at(16'h0010);
  endtask

  // Random mix of writes and evaluations over several point counts.
  task automatic test_random_mix();
    logic [CNT_W-1:0]  count;
    logic [FRAC_W-1:0] t;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       count = 7'd4;
        1:       count = 7'(MAX_POINTS);
        2:       count = CNT_W'($urandom_range(0, 127));
        default: count = CNT_W'($urandom_range(MIN_POINTS, MAX_POINTS));
      endcase
      set_ring_size(count);
      // Run one phase back to back on both sides.
      if (p == 4) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else begin
        tx_idle_pct = 32;
        rx_idle_pct = 32;
      end
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if ($urandom_range(0, 99) < 30) begin
          write_point(IDX_W'($urandom), rand_coord(), rand_coord(), rand_coord());
        end else begin
          case ($urandom_range(0, 15))
            0:       t = 16'h0000;
            1:       t = 16'hFFFF;
            2:       t = 16'($urandom_range(0, 127) << 10);
            default: t = FRAC_W'($urandom);
          endcase
          eval_at(t);
        end
      end
    end
    tx_idle_pct = 32;
    rx_idle_pct = 32;
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      error_count++;
    end
  endtask

  // Compare each sample the block hands over with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_samples.size() == 0) begin
        $display("%0t: unexpected sample, expected none actual pos %h %h %h", $time,
                 pos_x_o, pos_y_o, pos_z_o);
        error_count++;
      end else begin
        oldest_sample = expected_samples.pop_front();
        check_field("pos_x", oldest_sample.pos[0], pos_x_o);
        check_field("pos_y", oldest_sample.pos[1], pos_y_o);
        check_field("pos_z", oldest_sample.pos[2], pos_z_o);
        check_field("tangent_x", oldest_sample.tan[0], tangent_x_o);
        check_field("tangent_y", oldest_sample.tan[1], tangent_y_o);
        check_field("tangent_z", oldest_sample.tan[2], tangent_z_o);
        check_field("saturated", 32'(oldest_sample.sat), 32'(saturated_o));
      end
    end
  end

  // Stall the result side at random.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("closed_catmull_rom_evaluator_top_tb NOT OK");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    operation_i   = 1'b0;
    point_index_i = '0;
    coord_x_i     = '0;
    coord_y_i     = '0;
    coord_z_i     = '0;
    global_t_i    = '0;
    out_ready_i   = 1'b0;
    ring_size     = RESET_COUNT;
    tx_idle_pct   = 32;
    rx_idle_pct   = 32;
    cycle_count   = 0;
    error_count   = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    fill_table();
    test_reset_count();
    test_saturation();
    test_count_clamp();
    test_write_then_eval();
    test_random_mix();

    // Wait for the last samples, then watch for strays.
    drain_results();
    if (error_count == 0) begin
      $display("closed_catmull_rom_evaluator_top_tb OK");
    end else begin
      $display("closed_catmull_rom_evaluator_top_tb NOT OK");
    end
    $finish;
  end

endmodule

>>> closed_catmull_rom_evaluator_top.f
src/ccr_pkg.sv
src/closed_catmull_rom_evaluator_top.sv
tb/closed_catmull_rom_evaluator_top_tb.sv
